/* src/pls_pkg.sv */
package pls_pkg;

  // List depth and derived widths
  localparam int unsigned CAPACITY = 64;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned DATA_W   = 32;

  typedef enum logic [2:0] {
    K_CLEAR      = 3'd0,
    K_PUSH_FRONT = 3'd1,
    K_PUSH_BACK  = 3'd2,
    K_INSERT_AT  = 3'd3,
    K_POP_FRONT  = 3'd4,
    K_POP_BACK   = 3'd5,
    K_REMOVE_AT  = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_EMPTY  = 2'd1,
    STAT_BADPOS = 2'd2,
    STAT_FULL   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TAKE,
    S_CAPT,
    S_LOOP,
    S_RD,
    S_WR,
    S_PUT,
    S_DONE
  } state_e;

  typedef struct packed {
    kind_e               kind;
    logic signed [31:0]  value;
    logic [6:0]          position;
  } in_item_t;

  typedef struct packed {
    status_e             status;
    logic signed [31:0]  removed_value;
    logic [6:0]          count;
  } out_item_t;

  // Request from the sequencer to the entry store
  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [DATA_W-1:0]  wdata;
    logic [IDX_W-1:0]   raddr;
  } mem_req_t;

endpackage

/* src/pls_mem.sv */
module pls_mem
  import pls_pkg::*;
(
  input  logic              clk_i,
  input  mem_req_t          req_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [CAPACITY];
  logic [DATA_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/pls_ctrl.sv */
module pls_ctrl
  import pls_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_data_i,
  output mem_req_t          mem_req_o,
  input  logic [DATA_W-1:0] mem_rdata_i,
  output logic              res_valid_o,
  output out_item_t         res_o,
  input  logic              res_take_i
);

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   ptr_q, ptr_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               ins_q, ins_d;
  logic [DATA_W-1:0]  value_q, value_d;
  logic [COUNT_W-1:0] count_q, count_d;
  status_e            status_q, status_d;
  logic [DATA_W-1:0]  removed_q, removed_d;

  logic [COUNT_W-1:0] pos_m1;
  logic [COUNT_W-1:0] cnt_m1;
  logic [COUNT_W-1:0] ptr_p1;
  logic               pos_ok;
  logic               full;
  logic               empty;

  assign pos_m1 = in_data_i.position - COUNT_W'(1);
  assign cnt_m1 = count_q - COUNT_W'(1);
  assign ptr_p1 = COUNT_W'(ptr_q) + COUNT_W'(1);
  assign pos_ok = (in_data_i.position != '0) && (in_data_i.position <= count_q);
  assign full   = (count_q >= COUNT_W'(CAPACITY));
  assign empty  = (count_q == '0);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // Working registers of the current command
  always_ff @(posedge clk_i) begin
    ptr_q     <= ptr_d;
    idx_q     <= idx_d;
    ins_q     <= ins_d;
    value_q   <= value_d;
    status_q  <= status_d;
    removed_q <= removed_d;
  end

  // Sequence one command: decode, shift entries one at a time, finish
  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    idx_d     = idx_q;
    ins_d     = ins_q;
    value_d   = value_q;
    count_d   = count_q;
    status_d  = status_q;
    removed_d = removed_q;
    mem_req_o = '{we: 1'b0, waddr: ptr_q, wdata: mem_rdata_i, raddr: ptr_q};
    res_valid_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          status_d  = STAT_OK;
          removed_d = '0;
          value_d   = in_data_i.value;
          state_d   = S_DONE;
          case (in_data_i.kind) inside
            K_CLEAR: begin
              count_d = '0;
            end
            K_PUSH_FRONT, K_PUSH_BACK: begin
              if (full) begin
                status_d = STAT_FULL;
              end else begin
                ins_d   = 1'b1;
                ptr_d   = count_q[IDX_W-1:0];
                idx_d   = (in_data_i.kind == K_PUSH_FRONT) ? '0 : count_q[IDX_W-1:0];
                state_d = S_LOOP;
              end
            end
            K_INSERT_AT: begin
              if (!pos_ok) begin
                status_d = STAT_BADPOS;
              end else if (full) begin
                status_d = STAT_FULL;
              end else begin
                ins_d   = 1'b1;
                ptr_d   = count_q[IDX_W-1:0];
                idx_d   = pos_m1[IDX_W-1:0];
                state_d = S_LOOP;
              end
            end
            K_POP_FRONT, K_POP_BACK: begin
              if (empty) begin
                status_d = STAT_EMPTY;
              end else begin
                ins_d   = 1'b0;
                ptr_d   = (in_data_i.kind == K_POP_FRONT) ? '0 : cnt_m1[IDX_W-1:0];
                state_d = S_TAKE;
              end
            end
            K_REMOVE_AT: begin
              if (empty) begin
                status_d = STAT_EMPTY;
              end else if (!pos_ok) begin
                status_d = STAT_BADPOS;
              end else begin
                ins_d   = 1'b0;
                ptr_d   = pos_m1[IDX_W-1:0];
                state_d = S_TAKE;
              end
            end
            default: ;
          endcase
        end
      end
      // Fetch the entry being removed
      S_TAKE: begin
        mem_req_o.raddr = ptr_q;
        state_d         = S_CAPT;
      end
      S_CAPT: begin
        removed_d = mem_rdata_i;
        state_d   = S_LOOP;
      end
      // Decide whether another entry has to move
      S_LOOP: begin
        if (ins_q) begin
          state_d = (ptr_q != idx_q) ? S_RD : S_PUT;
        end else if (ptr_p1 < count_q) begin
          state_d = S_RD;
        end else begin
          count_d = cnt_m1;
          state_d = S_DONE;
        end
      end
      S_RD: begin
        mem_req_o.raddr = ins_q ? (ptr_q - IDX_W'(1)) : (ptr_q + IDX_W'(1));
        state_d         = S_WR;
      end
      // Move the neighbour into the slot under the pointer
      S_WR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = ptr_q;
        mem_req_o.wdata = mem_rdata_i;
        ptr_d           = ins_q ? (ptr_q - IDX_W'(1)) : (ptr_q + IDX_W'(1));
        state_d         = S_LOOP;
      end
      // Fill the opened gap
      S_PUT: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = idx_q;
        mem_req_o.wdata = value_q;
        count_d         = count_q + COUNT_W'(1);
        state_d         = S_DONE;
      end
      // Hold the result until the output stage takes it
      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign res_o      = '{status: status_q, removed_value: removed_q, count: count_q};

endmodule

/* src/positional_list_store.sv */
// Ordered list of up to 64 signed 32-bit values held in a single-port-write,
// registered-read memory, front at slot 0. Each command transfer returns one
// result transfer with status, removed value and the new count. Inserting or
// removing in the middle moves the entries behind the affected slot one at a
// time through the memory port, each one read and then written one slot over.
// A taken command is decoded, any entries behind its slot are moved, and its
// result is handed to the output register; the hand-over waits while the
// output register holds a stalled result. The input stalls while a command is
// being worked on; a finished result sits in the output register so the next
// command can be taken meanwhile.
module positional_list_store
  import pls_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  mem_req_t          mem_req;
  logic [DATA_W-1:0] mem_rdata;
  logic              res_valid;
  out_item_t         res;
  logic              res_take;
  logic              out_valid_q;
  out_item_t         out_data_q;

  pls_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_take_i  (res_take)
  );

  pls_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // Load the output register when it is empty or being drained
  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* src/pls_checker.sv */
module pls_checker
  import pls_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_item_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Block is busy in the cycle after taking a command
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("command taken while previous one in progress");

  // Count never exceeds capacity
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.count <= COUNT_W'(CAPACITY))
    else $error("count beyond capacity");

  // Failed commands remove nothing
  a_fail_no_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != STAT_OK) |-> out_data_o.removed_value == '0)
    else $error("removed value on failed command");

  // Empty report only on an empty list
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == STAT_EMPTY) |-> out_data_o.count == '0)
    else $error("empty status with entries present");

endmodule

bind positional_list_store pls_checker u_pls_checker (.*);
